@@ design/dezippered_gain_stage_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dezippered gain stage
// Shared property templates used by the checker.
// ---------------------------------------------------------------------------
`ifndef DEZIPPERED_GAIN_STAGE_UNIT_MACROS_SVH
`define DEZIPPERED_GAIN_STAGE_UNIT_MACROS_SVH

// same-cycle implication
`define DGS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DGS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dgs_pkg.sv @@
// ---------------------------------------------------------------------------
// Dezippered gain stage package
// Item types, merge control struct, sequencer states, register indexes and fixed constants.
// ---------------------------------------------------------------------------
`default_nettype none

package dgs_pkg;

  localparam int FIELDS = 4;
  localparam int GAIN_W = 18;
  localparam int SAMP_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 18'h3FFFF;
  localparam logic [GAIN_W-1:0] EPS_Q16  = 18'd65;
  localparam logic [16:0]       DZ_RATE  = 17'd83886;

  localparam logic REG_BUS_GAIN = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef samp_t [FIELDS-1:0] samp_vec_t;

  typedef struct packed {
    logic              block_start;
    logic [GAIN_W-1:0] target_gain;
    logic              source_silent;
    samp_t             sample_in_0;
    samp_t             sample_in_1;
    samp_t             sample_in_2;
    samp_t             sample_in_3;
  } in_item_t;

  typedef struct packed {
    samp_t             sample_out_0;
    samp_t             sample_out_1;
    samp_t             sample_out_2;
    samp_t             sample_out_3;
    logic [GAIN_W-1:0] applied_gain;
  } out_item_t;

  typedef struct packed {
    logic              silent;
    logic [2:0]        channels;
    logic [GAIN_W-1:0] gain;
  } merge_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DES,
    S_BLOCK,
    S_SNAP,
    S_STEP,
    S_UPD,
    S_LANE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/dgs_lane.sv @@
// ---------------------------------------------------------------------------
// Gain lane
// Registered sample-by-gain product, round half up and saturate to Q1.15.
// ---------------------------------------------------------------------------
`default_nettype none

module dgs_lane (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire dgs_pkg::samp_t                sample,
  input  wire logic [dgs_pkg::GAIN_W-1:0]    gain,
  output dgs_pkg::samp_t                     res
);

  logic signed [34:0] prod;
  logic signed [34:0] rnd;
  logic signed [18:0] q;
  logic signed [18:0] g_s;

  assign g_s = {1'b0, gain};

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 35'(sample) * 35'(g_s);
    end
  end

  always_comb begin
    rnd = prod + 35'sd32768;
    q   = rnd[34:16];
    if (q > 19'sd32767) begin
      res = 16'sh7FFF;
    end else if (q < -19'sd32768) begin
      res = -16'sh8000;
    end else begin
      res = q[15:0];
    end
  end

endmodule

`default_nettype wire

@@ design/dgs_merge.sv @@
// ---------------------------------------------------------------------------
// Lane merge
// Masks inactive and silent lanes and packs the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module dgs_merge (
  input  wire dgs_pkg::samp_vec_t    lane_res,
  input  wire dgs_pkg::merge_ctrl_t  ctrl,
  output dgs_pkg::out_item_t         item
);

  dgs_pkg::samp_vec_t masked;

  always_comb begin
    for (int i = 0; i < dgs_pkg::FIELDS; i++) begin
      if (!ctrl.silent && (4'(i) < {1'b0, ctrl.channels})) begin
        masked[i] = lane_res[i];
      end else begin
        masked[i] = '0;
      end
    end
    item.sample_out_0 = masked[0];
    item.sample_out_1 = masked[1];
    item.sample_out_2 = masked[2];
    item.sample_out_3 = masked[3];
    item.applied_gain = ctrl.silent ? '0 : ctrl.gain;
  end

endmodule

`default_nettype wire

@@ design/dezippered_gain_stage_unit.sv @@
// ---------------------------------------------------------------------------
// Dezippered gain stage
// One-pole gain glide with snap and silent handling over parallel lanes.
// ---------------------------------------------------------------------------
// A frame is taken when frame_valid is high and frame_stall low; its result
// goes to a holding register, so the next frame may enter while a result
// waits. A sequencer chains three multiplies (bus times target gain, glide
// step, lane products), each followed by a register. A block-start frame
// passes through S_DES, S_BLOCK and S_SNAP before S_STEP, any other frame
// starts at S_STEP; a frame of a silent block skips S_UPD and S_LANE. Lanes above
// channel_count, or above LANES, output zero. Registers: bus_gain at 0x0,
// channel_count at 0x4. There is no clearing pass.
`default_nettype none

module dezippered_gain_stage_unit #(
  parameter int LANES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 frame_valid,
  output logic                      frame_stall,
  input  wire dgs_pkg::in_item_t    frame,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output dgs_pkg::out_item_t        result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int ACT = (LANES < dgs_pkg::FIELDS) ? LANES : dgs_pkg::FIELDS;
  localparam int GW  = dgs_pkg::GAIN_W;

  // configuration
  logic [GW-1:0] bus_gain;
  logic [2:0]    channel_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_gain      <= 18'd65536;
      channel_count <= 3'd2;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        dgs_pkg::REG_BUS_GAIN: bus_gain      <= pwdata[GW-1:0];
        dgs_pkg::REG_CHANNELS: channel_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dgs_pkg::REG_BUS_GAIN: prdata = {14'd0, bus_gain};
      dgs_pkg::REG_CHANNELS: prdata = {29'd0, channel_count};
      default:               prdata = '0;
    endcase
  end

  // sequencer and gain state
  dgs_pkg::state_t   state, state_next;
  dgs_pkg::in_item_t frame_reg;
  logic [35:0]       gprod;
  logic [34:0]       mstep;
  logic              step_up;
  logic [GW-1:0]     current_gain;
  logic [GW-1:0]     desired_gain;
  logic              first_block;
  logic              smoothing_active;
  logic              block_silent;

  logic [36:0]       dsum;
  logic [20:0]       dq;
  logic [GW-1:0]     snap_start;
  logic [GW-1:0]     snap_diff;
  logic [GW-1:0]     glide_diff;
  logic [35:0]       ssum;
  logic [GW-1:0]     step;
  logic              accept;
  logic              load_lanes;
  logic              load_result;

  assign accept = frame_valid && !frame_stall;

  always_comb begin
    dsum       = 37'(gprod) + 37'd32768;
    dq         = dsum[36:16];
    snap_start = first_block ? desired_gain : current_gain;
    snap_diff  = (snap_start > desired_gain) ? snap_start - desired_gain
                                             : desired_gain - snap_start;
    glide_diff = (desired_gain >= current_gain) ? desired_gain - current_gain
                                                : current_gain - desired_gain;
    ssum       = 36'(mstep) + 36'd8388608;
    step       = 18'(ssum[35:24]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    frame_stall = 1'b1;
    load_lanes  = 1'b0;
    load_result = 1'b0;
    unique case (state)
      dgs_pkg::S_IDLE: begin
        frame_stall = 1'b0;
        if (frame_valid) begin
          state_next = frame.block_start ? dgs_pkg::S_DES : dgs_pkg::S_STEP;
        end
      end
      dgs_pkg::S_DES:   state_next = dgs_pkg::S_BLOCK;
      dgs_pkg::S_BLOCK: state_next = dgs_pkg::S_SNAP;
      dgs_pkg::S_SNAP:  state_next = dgs_pkg::S_STEP;
      dgs_pkg::S_STEP:  state_next = block_silent ? dgs_pkg::S_DONE : dgs_pkg::S_UPD;
      dgs_pkg::S_UPD:   state_next = dgs_pkg::S_LANE;
      dgs_pkg::S_LANE: begin
        load_lanes = 1'b1;
        state_next = dgs_pkg::S_DONE;
      end
      dgs_pkg::S_DONE: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = dgs_pkg::S_IDLE;
        end
      end
      default: state_next = dgs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_reg <= frame;
    end
    if (state == dgs_pkg::S_DES) begin
      gprod <= 36'(bus_gain) * 36'(frame_reg.target_gain);
    end
    if (state == dgs_pkg::S_STEP) begin
      mstep   <= 35'(glide_diff) * 35'(dgs_pkg::DZ_RATE);
      step_up <= desired_gain >= current_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_gain     <= '0;
      desired_gain     <= '0;
      first_block      <= 1'b1;
      smoothing_active <= 1'b0;
      block_silent     <= 1'b0;
    end else begin
      unique case (state)
        dgs_pkg::S_BLOCK: begin
          desired_gain <= (dq > 21'(dgs_pkg::GAIN_MAX)) ? dgs_pkg::GAIN_MAX : dq[GW-1:0];
          block_silent <= frame_reg.source_silent;
        end
        dgs_pkg::S_SNAP: begin
          if (!block_silent) begin
            first_block <= 1'b0;
            if (snap_diff <= dgs_pkg::EPS_Q16) begin
              current_gain     <= desired_gain;
              smoothing_active <= 1'b0;
            end else begin
              current_gain     <= snap_start;
              smoothing_active <= 1'b1;
            end
          end
        end
        dgs_pkg::S_UPD: begin
          if (!smoothing_active) begin
            current_gain <= desired_gain;
          end else if (step_up) begin
            current_gain <= current_gain + step;
          end else begin
            current_gain <= current_gain - step;
          end
        end
        default: ;
      endcase
    end
  end

  // lanes
  dgs_pkg::samp_vec_t samp_in;
  dgs_pkg::samp_vec_t lane_res;

  assign samp_in[0] = frame_reg.sample_in_0;
  assign samp_in[1] = frame_reg.sample_in_1;
  assign samp_in[2] = frame_reg.sample_in_2;
  assign samp_in[3] = frame_reg.sample_in_3;

  for (genvar i = 0; i < dgs_pkg::FIELDS; i++) begin : g_lane
    if (i < ACT) begin : g_on
      dgs_lane u_lane (
        .clk    (clk),
        .load   (load_lanes),
        .sample (samp_in[i]),
        .gain   (current_gain),
        .res    (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  dgs_pkg::merge_ctrl_t ctrl;
  dgs_pkg::out_item_t   merged;

  assign ctrl.silent   = block_silent;
  assign ctrl.channels = channel_count;
  assign ctrl.gain     = current_gain;

  dgs_merge u_merge (
    .lane_res (lane_res),
    .ctrl     (ctrl),
    .item     (merged)
  );

  // result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= merged;
    end
  end

endmodule

`default_nettype wire

@@ design/dgs_checker.sv @@
// ---------------------------------------------------------------------------
// Dezippered gain stage checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dezippered_gain_stage_unit_macros.svh"

module dgs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                frame_valid,
  input wire logic                frame_stall,
  input wire dgs_pkg::out_item_t  result,
  input wire logic                result_valid,
  input wire logic                result_stall
);

  `DGS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result item changed")

  `DGS_ASSERT_IMPL(a_zero_gain, clk, rst, result_valid && (result.applied_gain == '0), (result.sample_out_0 == '0) && (result.sample_out_1 == '0) && (result.sample_out_2 == '0) && (result.sample_out_3 == '0), "nonzero sample with zero gain")

  `DGS_ASSERT_NEXT(a_busy_after_accept, clk, rst, frame_valid && !frame_stall, frame_stall, "item accepted while one is in flight")

endmodule

bind dezippered_gain_stage_unit dgs_checker u_dgs_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

`default_nettype wire
